### sv/kds_pkg.sv
`timescale 1ns / 1ps
// Package for kth_distinct_subsequence: widths, codes and shared types.
// Used by kds_core and by the top level.
package kds_pkg;

    localparam int MAX_LEN  = 64;
    localparam int ALPHABET = 26;
    localparam int LETTER_W = 5;
    localparam int POS_W    = $clog2(MAX_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int RANK_W   = 60;
    localparam int CNT_W    = RANK_W + 1;
    localparam int APB_DW   = 64;
    localparam int APB_AW   = 3;
    localparam int TDATA_W  = 8;

    localparam logic [APB_AW-1:0] RANK_ADDR = APB_AW'(0);

    typedef struct packed {
        logic                valid;
        logic [LETTER_W-1:0] letter;
        logic                last;
        logic                found;
    } out_push_t;

endpackage

### sv/kds_core.sv
`timescale 1ns / 1ps
// Sequencer, letter and count memories, and the shared subtract/compare unit.
// Depends on kds_pkg; the top level supplies the rank and the output slot.
module kds_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [kds_pkg::LETTER_W-1:0]  in_letter,
    input  logic                          in_eos,
    output logic                          in_ready,
    input  logic [kds_pkg::RANK_W-1:0]    rank,
    input  logic                          out_free,
    output kds_pkg::out_push_t            push
);
    import kds_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_B_RDL, ST_B_RDC, ST_B_UPD, ST_B_SAT, ST_CHECK,
        ST_S_ADDR, ST_S_DATA, ST_L_ADDR, ST_L_CMP, ST_EMIT, ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LEN_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       rt_reg, rt_next;
    logic [CNT_W:0]         tmp_reg, tmp_next;
    logic                   hv_reg, hv_next;
    logic [ALPHABET-1:0]    np_valid_reg, np_valid_next;
    logic [POS_W-1:0]       np_pos_reg [ALPHABET];
    logic [POS_W-1:0]       np_pos_next [ALPHABET];
    logic [ALPHABET-1:0]    fp_valid_reg, fp_valid_next;
    logic [POS_W-1:0]       fp_pos_reg [ALPHABET];
    logic [POS_W-1:0]       fp_pos_next [ALPHABET];
    logic [RANK_W-1:0]      rem_reg, rem_next;
    logic [LEN_W-1:0]       cur_reg, cur_next;
    logic [LEN_W-1:0]       j_reg, j_next;
    logic [LETTER_W-1:0]    c_reg, c_next;
    logic [LETTER_W-1:0]    pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [LETTER_W-1:0]    nxt_reg, nxt_next;

    logic [LETTER_W-1:0]    letter_mem [MAX_LEN];
    logic [CNT_W-1:0]       sc_mem [MAX_LEN];
    logic [LETTER_W-1:0]    letter_rdata_reg;
    logic [CNT_W-1:0]       sc_rdata_reg;
    logic [POS_W-1:0]       l_raddr, l_waddr, sc_raddr, sc_waddr;
    logic                   l_we, sc_we;

    always_ff @(posedge aclk) begin
        letter_rdata_reg <= letter_mem[l_raddr];
        sc_rdata_reg     <= sc_mem[sc_raddr];
        if (l_we) begin
            letter_mem[l_waddr] <= in_letter;
        end
        if (sc_we) begin
            sc_mem[sc_waddr] <= rt_reg;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        logic [LEN_W-1:0] len_upd;
        logic [CNT_W-1:0] sub;
        state_next      = state_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        rt_next         = rt_reg;
        tmp_next        = tmp_reg;
        hv_next         = hv_reg;
        np_valid_next   = np_valid_reg;
        np_pos_next     = np_pos_reg;
        fp_valid_next   = fp_valid_reg;
        fp_pos_next     = fp_pos_reg;
        rem_next        = rem_reg;
        cur_next        = cur_reg;
        j_next          = j_reg;
        c_next          = c_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        nxt_next        = nxt_reg;
        l_raddr         = pos_reg[POS_W-1:0];
        l_waddr         = len_reg[POS_W-1:0];
        l_we            = 1'b0;
        sc_raddr        = np_pos_reg[letter_rdata_reg];
        sc_waddr        = pos_reg[POS_W-1:0];
        sc_we           = 1'b0;
        push            = '0;
        len_upd         = len_reg;
        sub             = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if ((in_letter < LETTER_W'(ALPHABET)) && (len_reg < LEN_W'(MAX_LEN))) begin
                        l_we    = 1'b1;
                        len_upd = len_reg + LEN_W'(1);
                    end
                    len_next = len_upd;
                    if (in_eos) begin
                        pos_next      = len_upd;
                        rt_next       = CNT_W'(1);
                        np_valid_next = '0;
                        state_next    = ST_B_RDL;
                    end
                end
            end
            ST_B_RDL: begin
                l_raddr = POS_W'(pos_reg - LEN_W'(1));
                if (pos_reg == '0) begin
                    state_next = ST_CHECK;
                end else begin
                    pos_next   = pos_reg - LEN_W'(1);
                    state_next = ST_B_RDC;
                end
            end
            ST_B_RDC: begin
                sc_raddr = np_pos_reg[letter_rdata_reg];
                sc_we    = 1'b1;
                hv_next  = np_valid_reg[letter_rdata_reg];
                np_valid_next[letter_rdata_reg] = 1'b1;
                np_pos_next[letter_rdata_reg]   = pos_reg[POS_W-1:0];
                state_next = ST_B_UPD;
            end
            ST_B_UPD: begin
                sub        = hv_reg ? sc_rdata_reg : '0;
                tmp_next   = {rt_reg, 1'b0} - {1'b0, sub};
                state_next = ST_B_SAT;
            end
            ST_B_SAT: begin
                if (tmp_reg > {2'b00, rank}) begin
                    rt_next = {1'b0, rank} + CNT_W'(1);
                end else begin
                    rt_next = tmp_reg[CNT_W-1:0];
                end
                state_next = ST_B_RDL;
            end
            ST_CHECK: begin
                pend_valid_next = 1'b0;
                if ((rank == '0) || (rt_reg <= {1'b0, rank})) begin
                    state_next = ST_FINISH;
                end else begin
                    rem_next      = rank;
                    cur_next      = '0;
                    j_next        = '0;
                    fp_valid_next = '0;
                    state_next    = ST_S_ADDR;
                end
            end
            ST_S_ADDR: begin
                l_raddr = j_reg[POS_W-1:0];
                if (j_reg >= len_reg) begin
                    c_next     = '0;
                    state_next = ST_L_ADDR;
                end else begin
                    state_next = ST_S_DATA;
                end
            end
            ST_S_DATA: begin
                if (!fp_valid_reg[letter_rdata_reg]) begin
                    fp_valid_next[letter_rdata_reg] = 1'b1;
                    fp_pos_next[letter_rdata_reg]   = j_reg[POS_W-1:0];
                end
                j_next     = j_reg + LEN_W'(1);
                state_next = ST_S_ADDR;
            end
            ST_L_ADDR: begin
                sc_raddr = fp_pos_reg[c_reg];
                if (c_reg == LETTER_W'(ALPHABET)) begin
                    state_next = ST_FINISH;
                end else if (fp_valid_reg[c_reg]) begin
                    state_next = ST_L_CMP;
                end else begin
                    c_next = c_reg + LETTER_W'(1);
                end
            end
            ST_L_CMP: begin
                if ({1'b0, rem_reg} > sc_rdata_reg) begin
                    rem_next   = RANK_W'({1'b0, rem_reg} - sc_rdata_reg);
                    c_next     = c_reg + LETTER_W'(1);
                    state_next = ST_L_ADDR;
                end else begin
                    rem_next   = rem_reg - RANK_W'(1);
                    cur_next   = {1'b0, fp_pos_reg[c_reg]} + LEN_W'(1);
                    nxt_next   = c_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!pend_valid_reg || out_free) begin
                    push.valid      = pend_valid_reg;
                    push.letter     = pend_reg;
                    push.found      = 1'b1;
                    pend_next       = nxt_reg;
                    pend_valid_next = 1'b1;
                    if (rem_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        j_next        = cur_reg;
                        fp_valid_next = '0;
                        state_next    = ST_S_ADDR;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    push.valid      = 1'b1;
                    push.letter     = pend_valid_reg ? pend_reg : '0;
                    push.last       = 1'b1;
                    push.found      = pend_valid_reg;
                    pend_valid_next = 1'b0;
                    len_next        = '0;
                    rt_next         = CNT_W'(1);
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            rt_reg         <= CNT_W'(1);
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            np_valid_reg   <= '0;
            fp_valid_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            rt_reg         <= rt_next;
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
            np_valid_reg   <= np_valid_next;
            fp_valid_reg   <= fp_valid_next;
        end
        pos_reg    <= pos_next;
        tmp_reg    <= tmp_next;
        hv_reg     <= hv_next;
        np_pos_reg <= np_pos_next;
        fp_pos_reg <= fp_pos_next;
        cur_reg    <= cur_next;
        j_reg      <= j_next;
        c_reg      <= c_next;
        pend_reg   <= pend_next;
        nxt_reg    <= nxt_next;
    end

endmodule

### sv/kth_distinct_subsequence.sv
`timescale 1ns / 1ps
// kth_distinct_subsequence: letters stream in one per transaction (0 = a); the
// transaction with tlast set closes the string (up to 64 letters, letters of 26
// and above are dropped) and starts the run. Each answer letter leaves as one
// result transaction with tuser = 1, tlast on the final letter; when rank is 0
// or fewer than rank distinct non-empty subsequences exist a single result with
// tuser = 0 and tlast = 1 comes out. Plain letters are taken while the core is
// idle. The closing letter starts a backward count over the stored letters, then
// per answer letter a scan of the remaining positions plus a pass over the
// alphabet letters: all passes go through one count memory read port and one
// subtract/compare unit, and no letter is accepted until the run's last result
// is handed over. rank lies at APB byte address 0 and resets to 1.
// Depends on kds_pkg and kds_core.
module kth_distinct_subsequence (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kds_pkg::TDATA_W-1:0]   s_tdata,   // [4:0] letter
    input  logic                          s_tlast,   // end_of_string
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kds_pkg::TDATA_W-1:0]   m_tdata,   // [4:0] out_letter
    output logic                          m_tlast,   // is_last
    output logic                          m_tuser,   // [0] found
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kds_pkg::APB_AW-1:0]    paddr,
    input  logic [kds_pkg::APB_DW-1:0]    pwdata,
    output logic [kds_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import kds_pkg::*;

    logic [RANK_W-1:0]   rank_reg;
    logic                m_tvalid_reg;
    logic [LETTER_W-1:0] m_letter_reg;
    logic                m_tlast_reg;
    logic                m_tuser_reg;
    logic                out_free;
    out_push_t           push;

    assign pready   = 1'b1;
    assign prdata   = (paddr == RANK_ADDR) ? APB_DW'(rank_reg) : '0;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= RANK_W'(1);
        end else if (psel && penable && pwrite && pready && (paddr == RANK_ADDR)) begin
            rank_reg <= pwdata[RANK_W-1:0];
        end
    end

    kds_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_letter (s_tdata[LETTER_W-1:0]),
        .in_eos    (s_tlast),
        .in_ready  (s_tready),
        .rank      (rank_reg),
        .out_free  (out_free),
        .push      (push)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (push.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (push.valid) begin
            m_letter_reg <= push.letter;
            m_tlast_reg  <= push.last;
            m_tuser_reg  <= push.found;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(m_letter_reg);
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### tb/tb_kth_distinct_subsequence.sv
`timescale 1ns / 1ps
// Self-checking testbench for kth_distinct_subsequence: streams strings, sets rank
// over APB and checks every result transaction against a predictor kept in this file.
// Depends on kds_pkg and the kth_distinct_subsequence RTL.
module tb_kth_distinct_subsequence;
    import kds_pkg::*;

    localparam int SETTLE_CYCLES    = 300;
    localparam int LONG_HOLD        = 600;
    localparam int WATCHDOG_LIMIT   = 40000;
    localparam int ITEMS_PER_REGIME = 115;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                eos;
    } letter_item_t;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
        logic                found;
    } answer_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;
    logic                m_tuser;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    letter_item_t        letter_q [$];
    answer_t             answer_q [$];
    logic [LETTER_W-1:0] str_letters [$];
    logic [RANK_W-1:0]   rank_val = RANK_W'(1);

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req      = 1'b0;
    int  hold_count    = 0;
    bit  s_fire        = 1'b0;
    int  items_queued  = 0;
    int  items_accepted = 0;
    int  strings_closed = 0;
    int  results_checked = 0;
    int  rank_writes   = 0;
    int  mismatches    = 0;
    int  stall_cycles  = 0;

    kth_distinct_subsequence i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // Count subsequences backward with saturation, then walk the answer forward.
    function automatic void solve_string();
        logic [63:0] start_cnt [MAX_LEN];
        int          pos_list [ALPHABET][$];
        answer_t     walk_q [$];
        answer_t     ans;
        logic [63:0] total;
        logic [63:0] rank64;
        logic [63:0] rem;
        int          len;
        int          c;
        int          p;
        bit          chosen;
        len    = str_letters.size();
        rank64 = 64'(rank_val);
        total  = 64'd1;
        for (int i = len - 1; i >= 0; i--) begin
            c = str_letters[i];
            start_cnt[i] = total;
            if (pos_list[c].size() > 0)
                total -= start_cnt[pos_list[c][$]];
            total += start_cnt[i];
            if (total > rank64)
                total = rank64 + 64'd1;
            pos_list[c].push_back(i);
        end
        if (rank64 != 0 && total - 64'd1 >= rank64) begin
            rem = rank64;
            while (rem != 0 && walk_q.size() < len) begin
                chosen = 1'b0;
                for (int k = 0; k < ALPHABET && !chosen; k++) begin
                    if (pos_list[k].size() == 0)
                        continue;
                    p = pos_list[k][$];
                    if (rem > start_cnt[p]) begin
                        rem -= start_cnt[p];
                        continue;
                    end
                    ans.letter = LETTER_W'(k);
                    ans.last   = 1'b0;
                    ans.found  = 1'b1;
                    walk_q.push_back(ans);
                    rem -= 64'd1;
                    for (int a = 0; a < ALPHABET; a++) begin
                        while (pos_list[a].size() > 0 && pos_list[a][$] <= p)
                            pos_list[a].delete(pos_list[a].size() - 1);
                    end
                    chosen = 1'b1;
                end
                if (!chosen)
                    break;
            end
        end
        if (walk_q.size() == 0) begin
            ans.letter = '0;
            ans.last   = 1'b1;
            ans.found  = 1'b0;
            walk_q.push_back(ans);
        end else begin
            walk_q[walk_q.size() - 1].last = 1'b1;
        end
        foreach (walk_q[j])
            answer_q.push_back(walk_q[j]);
        str_letters.delete();
    endfunction

    // Check results, update the predictor on accepted letters, run the watchdog.
    always @(posedge aclk) begin
        answer_t          exp_ans;
        logic [LETTER_W-1:0] ltr;
        bit               m_take;
        bit               s_take;
        bit               apb_take;
        m_take   = aresetn && m_tvalid && m_tready;
        s_take   = aresetn && s_tvalid && s_tready;
        apb_take = psel && penable && pwrite && pready;
        s_fire <= s_take;
        if (m_take) begin
            results_checked++;
            if (answer_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: tdata %0h last %0b user %0b",
                             m_tdata, m_tlast, m_tuser);
                mismatches++;
            end else begin
                exp_ans = answer_q.pop_front();
                if (m_tdata !== TDATA_W'(exp_ans.letter) || m_tlast !== exp_ans.last ||
                    m_tuser !== exp_ans.found) begin
                    if (mismatches < 10)
                        $display("result %0d: expected letter %0d last %0b found %0b,",
                                 results_checked, exp_ans.letter, exp_ans.last,
                                 exp_ans.found,
                                 " got %0d %0b %0b", m_tdata, m_tlast, m_tuser);
                    mismatches++;
                end
            end
        end
        if (s_take) begin
            items_accepted++;
            ltr = s_tdata[LETTER_W-1:0];
            if (ltr < ALPHABET && str_letters.size() < MAX_LEN)
                str_letters.push_back(ltr);
            if (s_tlast) begin
                strings_closed++;
                solve_string();
            end
        end
        if (m_take || s_take || apb_take || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", stall_cycles);
            $display("kth_distinct_subsequence: mismatch");
            $finish;
        end
    end

    // Letter sender: hold an offered transaction until taken, idle at random.
    always @(negedge aclk) begin
        letter_item_t itm;
        if (aresetn && (!s_tvalid || s_fire)) begin
            if (letter_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                itm = letter_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= TDATA_W'(itm.letter);
                s_tlast  <= itm.eos;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: stall at random, once hold off for a long stretch.
    always @(negedge aclk) begin
        if (hold_req && hold_count < LONG_HOLD) begin
            hold_count <= hold_count + 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic queue_letter(input int ltr, input bit eos);
        letter_item_t itm;
        itm.letter = LETTER_W'(ltr);
        itm.eos    = eos;
        letter_q.push_back(itm);
        items_queued++;
    endtask

    task automatic queue_string(input int len, input int span);
        int ltr;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 4)
                ltr = $urandom_range(26, 31);
            else
                ltr = $urandom_range(0, span - 1);
            queue_letter(ltr, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (items_accepted != items_queued || answer_q.size() != 0);
    endtask

    task automatic set_rank(input logic [APB_DW-1:0] wdata);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= RANK_ADDR;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rank_val = wdata[RANK_W-1:0];
        rank_writes++;
    endtask

    function automatic logic [APB_DW-1:0] pick_rank();
        logic [APB_DW-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v[RANK_W-1:0] = RANK_W'(1);
            1: v[RANK_W-1:0] = '1;
            2: v[RANK_W-1:0] = '0;
            3, 4: v[RANK_W-1:0] = RANK_W'($urandom_range(1, 30));
            5, 6: v[RANK_W-1:0] = RANK_W'($urandom_range(1, 5000));
            default: v[RANK_W-1:0] = v[RANK_W-1:0] >> $urandom_range(0, RANK_W - 1);
        endcase
        return v;
    endfunction

    function automatic int pick_len();
        case ($urandom_range(0, 19))
            0, 1: return $urandom_range(40, MAX_LEN);
            2: return $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    initial begin
        int regime_end;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset rank: smallest letter, single letter, empty string.
        queue_letter(1, 0);
        queue_letter(0, 1);
        queue_letter(25, 1);
        queue_letter(26, 0);
        queue_letter(31, 1);
        wait_drained();
        set_rank(64'd0);
        queue_letter(0, 1);
        wait_drained();
        set_rank('1);
        queue_letter(3, 0);
        queue_letter(7, 1);
        wait_drained();
        set_rank(64'hF000_0000_0000_0006);
        queue_letter(0, 0);
        queue_letter(1, 0);
        queue_letter(0, 1);
        wait_drained();
        set_rank(64'd7);
        queue_letter(0, 0);
        queue_letter(1, 0);
        queue_letter(0, 1);
        queue_letter(16, 0);
        queue_letter(8, 0);
        queue_letter(4, 0);
        queue_letter(2, 0);
        queue_letter(1, 1);
        wait_drained();

        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin
                    send_idle_pct = 31;
                    recv_idle_pct = 83;
                end
                1: begin
                    send_idle_pct = 83;
                    recv_idle_pct = 31;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            regime_end = items_queued + ITEMS_PER_REGIME;
            while (items_queued < regime_end) begin
                set_rank(pick_rank());
                if (regime == 2 && !hold_req) begin
                    queue_string(MAX_LEN, 26);
                    queue_string(12, 6);
                    hold_req = 1'b1;
                end
                repeat ($urandom_range(2, 5))
                    queue_string(pick_len(), $urandom_range(1, 26));
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("Covered %0d strings from %0d letters under %0d rank writes, %0d results.",
                 strings_closed, items_accepted, rank_writes, results_checked);
        $display("Included empty, oversized and out-of-alphabet strings, rank 0 and full rank.");
        if (mismatches == 0 && answer_q.size() == 0)
            $display("kth_distinct_subsequence: match");
        else
            $display("kth_distinct_subsequence: mismatch");
        $finish;
    end

endmodule
